/* hw/rtl/bmp24_stream_decoder_defines.svh */
// Assertion macros for the BMP 24-bit stream decoder.
`ifndef BMP24_STREAM_DECODER_DEFINES_SVH
`define BMP24_STREAM_DECODER_DEFINES_SVH
`ifndef SYNTH
// Checked on i_clk, switched off while reset is held.
`define BMP24_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bmp24 assertion failed");
// Checked on i_clk at every edge, reset included.
`define BMP24_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("bmp24 assertion failed");
`else
`define BMP24_ASSERT(label, prop)
`define BMP24_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* hw/rtl/bmp24_pkg.sv */
// Shared constants, types and header layout for the BMP 24-bit stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package bmp24_pkg;

    // Largest width or height accepted
    localparam int unsigned MAX_DIM   = 4096;
    localparam int unsigned DIM_W     = $clog2(MAX_DIM + 1);
    // Row size in bytes, padding included
    localparam int unsigned RB_W      = $clog2(MAX_DIM * 3 + 4);
    localparam int unsigned RAWX_W    = RB_W + DIM_W;
    localparam int unsigned RAW_CMP_W = (RAWX_W > 32) ? RAWX_W : 32;
    localparam int unsigned AREA_W    = 2 * DIM_W;

    localparam int unsigned IDX_W       = 24;
    localparam int unsigned OUT_DIM_W   = 13;
    localparam int unsigned OUT_DIM_MAX = (1 << OUT_DIM_W) - 1;

    // Command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // Header byte offsets
    localparam int unsigned OFS_SIG     = 0;
    localparam int unsigned OFS_FSIZE   = 2;
    localparam int unsigned OFS_PIXOFF  = 10;
    localparam int unsigned OFS_INFO    = 14;
    localparam int unsigned OFS_WIDTH   = 18;
    localparam int unsigned OFS_HEIGHT  = 22;
    localparam int unsigned OFS_PLANES  = 26;
    localparam int unsigned OFS_BPP     = 28;
    localparam int unsigned OFS_COMPR   = 30;
    localparam int unsigned OFS_RAW     = 34;
    localparam int unsigned OFS_COLORS  = 46;
    localparam int unsigned OFS_IMPORT  = 50;
    localparam int unsigned HDR_BYTES   = 54;

    localparam logic [7:0]  SIG_B      = 8'h42;
    localparam logic [7:0]  SIG_M      = 8'h4D;
    localparam logic [31:0] INFO_SIZE  = 32'd40;
    localparam logic [15:0] PLANES_ONE = 16'd1;
    localparam logic [15:0] BPP_24     = 16'd24;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CORRUPT = 2'd1,
        ST_UNSUP   = 2'd2
    } t_status;

    // One command per byte that gives anything: a pixel, a status, or both
    typedef struct packed {
        logic                 has_pix;
        logic                 has_stat;
        logic [IDX_W-1:0]     pix_idx;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        t_status              status;
        logic [OUT_DIM_W-1:0] width;
        logic [OUT_DIM_W-1:0] height;
    } t_cmd;

endpackage
`default_nettype wire

/* hw/rtl/bmp24_cmd_fifo.sv */
// Short command queue between the byte front end and the result back end.
`timescale 1ns / 1ps
`default_nettype none
module bmp24_cmd_fifo
    import bmp24_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_empty
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bmp24_front.sv */
// Front end: header capture and check, pixel row walk, command generation.
`timescale 1ns / 1ps
`default_nettype none
module bmp24_front
    import bmp24_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;

    // Dimension products are formed in the two beats after the height field
    localparam int unsigned PRE_DIMS_POS = OFS_HEIGHT + 4;
    localparam int unsigned PRE_RAW_POS  = PRE_DIMS_POS + 1;

    // Control
    logic [31:0]      r_byte_count;
    t_status          r_hdr_err;
    logic             r_pix_done;
    logic [RB_W-1:0]  r_bir;
    logic [DIM_W-1:0] r_row;
    logic [1:0]       r_phase;

    // Header fields
    logic [7:0]  r_sig_b;
    logic [7:0]  r_sig_m;
    logic [31:0] r_file_size;
    logic [31:0] r_pix_off;
    logic [31:0] r_info_size;
    logic [31:0] r_width;
    logic [31:0] r_height;
    logic [15:0] r_planes;
    logic [15:0] r_bpp;
    logic [31:0] r_compr;
    logic [31:0] r_raw;
    logic [31:0] r_colors;
    logic [23:0] r_important;

    // Precomputed sizes and pixel payload
    logic [RB_W-1:0]   r_w3;
    logic [RB_W-1:0]   r_row_bytes;
    logic [IDX_W-1:0]  r_area;
    logic [RAWX_W-1:0] r_raw_expect;
    logic [IDX_W-1:0]  r_pix_idx;
    logic [7:0]        r_red;
    logic [7:0]        r_green;

    logic                    w_in_hdr;
    logic                    w_hdr_wr;
    logic                    w_hdr_last;
    logic [5:0]              w_pos;
    logic [DIM_W-1:0]        w_w_d;
    logic [DIM_W-1:0]        w_h_d;
    logic [RB_W-1:0]         w_w3;
    logic [RB_W-1:0]         w_rb_sum;
    logic [RB_W-1:0]         w_rb;
    logic [AREA_W-1:0]       w_area_full;
    logic [AREA_W+IDX_W-1:0] w_area_ext;
    logic [RAWX_W-1:0]       w_raw_prod;
    logic                    w_sig_ok;
    logic                    w_imp_zero;
    t_status                 w_hdr_chk;
    t_status                 w_hdr_err_now;
    logic                    w_walk;
    logic                    w_in_pix;
    logic [RB_W-1:0]         w_bir_inc;
    logic                    w_row_end;
    logic [DIM_W-1:0]        w_row_inc;
    logic                    w_emit_pix;
    logic                    n_pix_done;
    logic [31:0]             w_bc_next;
    logic                    w_short;
    t_status                 w_stat;
    logic [OUT_DIM_W-1:0]    w_w_sat;
    logic [OUT_DIM_W-1:0]    w_h_sat;

    assign w_in_hdr   = (r_byte_count < 32'(HDR_BYTES));
    assign w_hdr_wr   = i_accept && w_in_hdr;
    assign w_hdr_last = (r_byte_count == 32'(HDR_BYTES - 1));
    assign w_pos      = r_byte_count[5:0];

    // Dimensions only matter once they pass the MAX_DIM check, so narrow copies do
    assign w_w_d       = r_width[DIM_W-1:0];
    assign w_h_d       = r_height[DIM_W-1:0];
    assign w_w3        = RB_W'({w_w_d, 1'b0}) + RB_W'(w_w_d);
    assign w_rb_sum    = w_w3 + RB_W'(3);
    assign w_rb        = {w_rb_sum[RB_W-1:2], 2'b00};
    assign w_area_full = w_w_d * w_h_d;
    assign w_area_ext  = {{IDX_W{1'b0}}, w_area_full};
    assign w_raw_prod  = r_row_bytes * RAWX_W'(w_h_d);

    assign w_sig_ok   = (r_sig_b == SIG_B) && (r_sig_m == SIG_M);
    assign w_imp_zero = (r_important == '0) && (i_data_byte == '0);

    // Header check, first failure wins
    always_comb begin
        priority if (!w_sig_ok) begin
            w_hdr_chk = ST_CORRUPT;
        end else if (r_info_size != INFO_SIZE) begin
            w_hdr_chk = ST_UNSUP;
        end else if (r_planes != PLANES_ONE || r_bpp != BPP_24 || r_compr != '0 ||
                     r_colors != '0 || !w_imp_zero) begin
            w_hdr_chk = ST_UNSUP;
        end else if (r_width > 32'(MAX_DIM) || r_height > 32'(MAX_DIM)) begin
            w_hdr_chk = ST_UNSUP;
        end else if (r_raw != '0 &&
                     RAW_CMP_W'(r_raw) != RAW_CMP_W'(r_raw_expect)) begin
            w_hdr_chk = ST_CORRUPT;
        end else if (r_pix_off != 32'(HDR_BYTES)) begin
            w_hdr_chk = ST_CORRUPT;
        end else begin
            w_hdr_chk = ST_OK;
        end
    end

    assign w_hdr_err_now = w_hdr_last ? w_hdr_chk : r_hdr_err;

    // Pixel walk
    assign w_walk     = i_accept && !w_in_hdr && (r_hdr_err == ST_OK) && !r_pix_done;
    assign w_in_pix   = (r_bir < r_w3);
    assign w_bir_inc  = r_bir + RB_W'(1);
    assign w_row_end  = (w_bir_inc >= r_row_bytes);
    assign w_row_inc  = r_row + DIM_W'(1);
    assign w_emit_pix = w_walk && w_in_pix && (r_phase == PH_BLUE);

    always_comb begin
        n_pix_done = r_pix_done;
        if (i_accept && w_hdr_last && w_hdr_chk == ST_OK) begin
            n_pix_done = (r_width == '0) || (r_height == '0);
        end else if (w_walk && w_row_end && w_row_inc >= w_h_d) begin
            n_pix_done = 1'b1;
        end
    end

    // Final status
    assign w_bc_next = (r_byte_count == '1) ? r_byte_count : r_byte_count + 32'd1;
    assign w_short   = (w_bc_next < 32'(HDR_BYTES));
    assign w_w_sat   = (r_width > 32'(OUT_DIM_MAX)) ? OUT_DIM_W'(OUT_DIM_MAX)
                                                    : r_width[OUT_DIM_W-1:0];
    assign w_h_sat   = (r_height > 32'(OUT_DIM_MAX)) ? OUT_DIM_W'(OUT_DIM_MAX)
                                                     : r_height[OUT_DIM_W-1:0];

    always_comb begin
        priority if (w_short) begin
            w_stat = ST_CORRUPT;
        end else if (!w_sig_ok || w_bc_next == '1 || r_file_size != w_bc_next) begin
            w_stat = ST_CORRUPT;
        end else if (w_hdr_err_now != ST_OK) begin
            w_stat = w_hdr_err_now;
        end else if (!n_pix_done) begin
            w_stat = ST_CORRUPT;
        end else begin
            w_stat = ST_OK;
        end
    end

    always_comb begin
        o_cmd.has_pix  = w_emit_pix;
        o_cmd.has_stat = i_accept && i_last_byte;
        o_cmd.pix_idx  = r_pix_idx;
        o_cmd.red      = r_red;
        o_cmd.green    = r_green;
        o_cmd.blue     = i_data_byte;
        o_cmd.status   = w_stat;
        o_cmd.width    = w_short ? '0 : w_w_sat;
        o_cmd.height   = w_short ? '0 : w_h_sat;
    end

    assign o_cmd_valid = o_cmd.has_pix || o_cmd.has_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_hdr_err    <= ST_OK;
            r_pix_done   <= 1'b0;
            r_bir        <= '0;
            r_row        <= '0;
            r_phase      <= PH_RED;
        end else if (i_accept) begin
            if (i_last_byte) begin
                // back to the start for the next file
                r_byte_count <= '0;
                r_hdr_err    <= ST_OK;
                r_pix_done   <= 1'b0;
                r_bir        <= '0;
                r_row        <= '0;
                r_phase      <= PH_RED;
            end else begin
                r_byte_count <= w_bc_next;
                r_pix_done   <= n_pix_done;
                if (w_hdr_last) begin
                    r_hdr_err <= w_hdr_chk;
                end
                if (w_walk) begin
                    if (w_row_end) begin
                        r_bir   <= '0;
                        r_row   <= w_row_inc;
                        r_phase <= PH_RED;
                    end else begin
                        r_bir <= w_bir_inc;
                        if (w_in_pix) begin
                            r_phase <= (r_phase == PH_BLUE) ? PH_RED : r_phase + 2'd1;
                        end
                    end
                end
            end
        end
    end

    // Payload: header fields by byte position, sizes, held colours
    always_ff @(posedge i_clk) begin
        if (w_hdr_wr && w_pos == 6'(OFS_SIG)) begin
            r_sig_b <= i_data_byte;
        end
        if (w_hdr_wr && w_pos == 6'(OFS_SIG + 1)) begin
            r_sig_m <= i_data_byte;
        end
        for (int k = 0; k < 4; k++) begin
            if (w_hdr_wr && w_pos == 6'(OFS_FSIZE + k))  r_file_size[8*k +: 8] <= i_data_byte;
            if (w_hdr_wr && w_pos == 6'(OFS_PIXOFF + k)) r_pix_off[8*k +: 8]   <= i_data_byte;
            if (w_hdr_wr && w_pos == 6'(OFS_INFO + k))   r_info_size[8*k +: 8] <= i_data_byte;
            if (w_hdr_wr && w_pos == 6'(OFS_WIDTH + k))  r_width[8*k +: 8]     <= i_data_byte;
            if (w_hdr_wr && w_pos == 6'(OFS_HEIGHT + k)) r_height[8*k +: 8]    <= i_data_byte;
            if (w_hdr_wr && w_pos == 6'(OFS_COMPR + k))  r_compr[8*k +: 8]     <= i_data_byte;
            if (w_hdr_wr && w_pos == 6'(OFS_RAW + k))    r_raw[8*k +: 8]       <= i_data_byte;
            if (w_hdr_wr && w_pos == 6'(OFS_COLORS + k)) r_colors[8*k +: 8]    <= i_data_byte;
        end
        for (int k = 0; k < 2; k++) begin
            if (w_hdr_wr && w_pos == 6'(OFS_PLANES + k)) r_planes[8*k +: 8] <= i_data_byte;
            if (w_hdr_wr && w_pos == 6'(OFS_BPP + k))    r_bpp[8*k +: 8]    <= i_data_byte;
        end
        // top byte of the important-colours field is checked as it arrives
        for (int k = 0; k < 3; k++) begin
            if (w_hdr_wr && w_pos == 6'(OFS_IMPORT + k)) r_important[8*k +: 8] <= i_data_byte;
        end

        if (i_accept && r_byte_count == 32'(PRE_DIMS_POS)) begin
            r_w3        <= w_w3;
            r_row_bytes <= w_rb;
            r_area      <= w_area_ext[IDX_W-1:0];
        end
        if (i_accept && r_byte_count == 32'(PRE_RAW_POS)) begin
            r_raw_expect <= w_raw_prod;
        end

        // Destination index counts down by one per pixel across the whole image
        if (i_accept && w_hdr_last) begin
            r_pix_idx <= r_area - IDX_W'(1);
        end else if (w_emit_pix) begin
            r_pix_idx <= r_pix_idx - IDX_W'(1);
        end

        if (w_walk && w_in_pix && r_phase == PH_RED) begin
            r_red <= i_data_byte;
        end
        if (w_walk && w_in_pix && r_phase == PH_GREEN) begin
            r_green <= i_data_byte;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bmp24_back.sv */
// Back end: expands commands into result beats through an output register.
`timescale 1ns / 1ps
`default_nettype none
module bmp24_back
    import bmp24_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  t_cmd                 i_head,
    output logic                 o_head_rd,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic                 o_item_kind,
    output logic [IDX_W-1:0]     o_pixel_index,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [1:0]           o_status,
    output logic [OUT_DIM_W-1:0] o_image_width,
    output logic [OUT_DIM_W-1:0] o_image_height,
    output logic                 o_end_of_run
);

    logic                 r_out_valid;
    logic                 r_second;
    logic                 r_kind;
    logic [IDX_W-1:0]     r_idx;
    logic [7:0]           r_red;
    logic [7:0]           r_green;
    logic [7:0]           r_blue;
    t_status              r_status;
    logic [OUT_DIM_W-1:0] r_width;
    logic [OUT_DIM_W-1:0] r_height;
    logic                 r_eor;

    logic w_load;
    logic w_take;
    logic w_send_pix;

    assign w_load     = !r_out_valid || i_pop;
    assign w_take     = w_load && i_head_valid;
    // pixel half of a two-beat command goes first; the head stays for the status
    assign w_send_pix = i_head.has_pix && !r_second;
    assign o_head_rd  = w_take && !(w_send_pix && i_head.has_stat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= i_head_valid;
            end
            if (w_take) begin
                r_second <= w_send_pix && i_head.has_stat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (w_send_pix) begin
                r_kind   <= KIND_PIXEL;
                r_idx    <= i_head.pix_idx;
                r_red    <= i_head.red;
                r_green  <= i_head.green;
                r_blue   <= i_head.blue;
                r_status <= ST_OK;
                r_width  <= '0;
                r_height <= '0;
                r_eor    <= 1'b0;
            end else begin
                r_kind   <= KIND_STATUS;
                r_idx    <= '0;
                r_red    <= '0;
                r_green  <= '0;
                r_blue   <= '0;
                r_status <= i_head.status;
                r_width  <= i_head.width;
                r_height <= i_head.height;
                r_eor    <= 1'b1;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_item_kind    = r_kind;
    assign o_pixel_index  = r_idx;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_status       = r_status;
    assign o_image_width  = r_width;
    assign o_image_height = r_height;
    assign o_end_of_run   = r_eor;

endmodule
`default_nettype wire

/* hw/rtl/bmp24_stream_decoder.sv */
// Path: the command for a taken byte is written into the queue, then moved into the output register;
//   the status beat of a last byte that also closes a pixel follows that pixel beat.
// Throughput: one byte per cycle, held back only when the four-entry command queue
//   is full; the output register gives one beat per cycle while pop is held and the queue is not empty.
// Reset: synchronous, active low; clears counters, header status, queue and output
//   valid. No clearing pass; header fields are rewritten by every file.
`timescale 1ns / 1ps
`default_nettype none
`include "bmp24_stream_decoder_defines.svh"
module bmp24_stream_decoder
    import bmp24_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte side
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_item_kind,
    output logic [IDX_W-1:0]     o_pixel_index,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [1:0]           o_status,
    output logic [OUT_DIM_W-1:0] o_image_width,
    output logic [OUT_DIM_W-1:0] o_image_height,
    output logic                 o_end_of_run
);

    // Structure:
    //   front  - counts bytes, captures the header fields by position, checks the
    //            header on byte 54, walks the pixel rows and forms commands.
    //            Dimension products are formed early (bytes 27 and 28) so the
    //            header check is only compares.
    //   queue  - short command queue; the front and back stall independently.
    //   back   - turns each command into one or two beats (pixel first, then
    //            status) through an output register.

    logic w_accept;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_q_wr;
    logic w_q_full;
    logic w_q_rd;
    logic w_q_empty;
    t_cmd w_q_head;

    // A beat is taken whenever the queue has room; bytes that give nothing are
    // taken too, so full is conservative by at most one slot.
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;
    assign w_q_wr   = w_accept && w_cmd_valid;

    bmp24_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    bmp24_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_cmd),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_head),
        .o_empty (w_q_empty)
    );

    bmp24_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (!w_q_empty),
        .i_head         (w_q_head),
        .o_head_rd      (w_q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_item_kind    (o_item_kind),
        .o_pixel_index  (o_pixel_index),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_status       (o_status),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_end_of_run   (o_end_of_run)
    );

    // Commands never land in a full queue
    `BMP24_ASSERT(a_q_no_overflow, w_q_wr |-> !w_q_full)
    // The back end only dequeues what is there
    `BMP24_ASSERT(a_q_no_underflow, w_q_rd |-> !w_q_empty)
    // A status beat closes the file
    `BMP24_ASSERT(a_status_beat, (!empty && o_item_kind == KIND_STATUS) |-> o_end_of_run)
    // Every beat carries a defined status code
    `BMP24_ASSERT(a_status_code, !empty |-> o_status <= ST_UNSUP)
    // Output is empty right after any reset edge
    `BMP24_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> empty)

endmodule
`default_nettype wire
